[hw/rtl/vrrq_pkg.sv]
package vrrq_pkg;

  localparam int unsigned RingBytesDefault = 4096;
  localparam int unsigned HeaderBytes      = 4;

  typedef enum logic [2:0] {
    CMD_PUSH_BEGIN = 3'd0,
    CMD_PUSH_BYTE  = 3'd1,
    CMD_PEEK       = 3'd2,
    CMD_READ_BYTE  = 3'd3,
    CMD_POP        = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_ORDER     = 3'd3,
    ST_OFFSET    = 3'd4
  } status_t;

  // datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LATCH    = 4'd1,  // capture input word
    OP_DECIDE   = 4'd2,  // evaluate command, update cursors, pick status
    OP_HDR_WR   = 4'd3,  // write one header byte
    OP_HDR_RD   = 4'd4,  // read one header byte
    OP_FINISH   = 4'd5,  // finish peek/pop/read_byte from fetched header
    OP_PAY_RD   = 4'd6,  // issue payload byte read
    OP_RESULT   = 4'd7   // load output register
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic need_hdr_wr;
    logic need_hdr_rd;
    logic need_pay_rd;
  } dp_stat_t;

endpackage

[hw/rtl/vrrq_ctrl.sv]
module vrrq_ctrl
  import vrrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_HWR    = 8'b0000_0100,
    S_HRD    = 8'b0000_1000,
    S_FIN    = 8'b0001_0000,
    S_PRD    = 8'b0010_0000,
    S_RES    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    dcmd.op   = OP_NONE;
    dcmd.idx  = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dcmd.op   = OP_LATCH;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        dcmd.op = OP_DECIDE;
        idx_nxt = 2'd0;
        if (stat.need_hdr_wr) state_nxt = S_HWR;
        else if (stat.need_hdr_rd) state_nxt = S_HRD;
        else state_nxt = S_RES;
      end
      S_HWR: begin
        dcmd.op = OP_HDR_WR;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = S_RES;
      end
      S_HRD: begin
        dcmd.op = OP_HDR_RD;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = S_FIN;
      end
      S_FIN: begin
        dcmd.op = OP_FINISH;
        if (stat.need_pay_rd) state_nxt = S_PRD;
        else state_nxt = S_RES;
      end
      S_PRD: begin
        dcmd.op   = OP_PAY_RD;
        state_nxt = S_RES;
      end
      S_RES: begin
        dcmd.op   = OP_RESULT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[hw/rtl/vrrq_dp.sv]
module vrrq_dp
  import vrrq_pkg::*;
#(
  parameter int unsigned RING_BYTES = RingBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_identifier,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_offset,
  input  logic        in_check_capacity,
  input  logic [15:0] in_capacity,
  input  dp_cmd_t     dcmd,
  output dp_stat_t    stat,
  output logic [2:0]  res_status,
  output logic [15:0] res_head_identifier,
  output logic [15:0] res_head_length,
  output logic [7:0]  res_read_data,
  output logic [$clog2(RING_BYTES/HeaderBytes+1)-1:0] res_records_held,
  output logic [$clog2(RING_BYTES+1)-1:0]             res_bytes_used
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned CW = $clog2(RING_BYTES + 1);
  localparam int unsigned RW = $clog2(RING_BYTES/HeaderBytes + 1);
  // wide enough for cursor + 4 + 65535 + 65535
  localparam int unsigned SW = (CW > 16 ? CW : 16) + 2;
  localparam logic [SW-1:0] RingS = SW'(RING_BYTES);
  localparam logic [SW-1:0] HdrS  = SW'(HeaderBytes);

  logic [7:0] mem [RING_BYTES];

  // queue state
  logic [CW-1:0] wr_cur_r, wrap_r, rd_cur_r, occ_r;
  logic [RW-1:0] cnt_r;
  logic          pend_r;
  logic [15:0]   prem_r;
  logic [CW-1:0] paddr_r;

  // latched input word
  logic [2:0]  cmd_r;
  logic [15:0] id_r, len_r, off_r, cap_r;
  logic [7:0]  dbyte_r;
  logic        chk_r;

  // per-item work registers
  logic [2:0]    st_r;
  logic [CW-1:0] hpos_r;
  logic          prd_r;
  logic [7:0]    hb_r [4];
  logic          rd_lat_r;
  logic [1:0]    rd_idx_r;
  logic [15:0]   hid_r, hlen_r;

  // memory port
  logic          mwe, mre;
  logic [AW-1:0] mwa, mra;
  logic [7:0]    mwd, mrd_r;

  logic [SW-1:0] total_s, wc_s, rc_s, occ_s, wrap_s;
  logic [CW-1:0] pos;
  logic [2:0]    dec_st;
  logic          fits;
  logic [15:0]   flen, fid;
  logic [SW-1:0] paddr_s;

  assign total_s = HdrS + SW'(len_r);
  assign wc_s    = SW'(wr_cur_r);
  assign rc_s    = SW'(rd_cur_r);
  assign occ_s   = SW'(occ_r);
  assign wrap_s  = SW'(wrap_r);

  // placement rules for push_begin
  always_comb begin
    pos  = wr_cur_r;
    fits = 1'b1;
    if (occ_s + total_s > RingS) fits = 1'b0;
    else if (wr_cur_r == wrap_r && wc_s + total_s > RingS) begin
      if (rc_s >= total_s) pos = '0;
      else fits = 1'b0;
    end else if (wr_cur_r < wrap_r && wc_s + total_s >= rc_s) fits = 1'b0;
  end

  assign flen = {hb_r[1], hb_r[0]};
  // last header byte is still in the read register while finishing
  assign fid  = {mrd_r, hb_r[2]};
  assign paddr_s = SW'(rd_cur_r) + HdrS + SW'(off_r);

  always_comb begin
    dec_st = ST_OK;
    case (cmd_r)
      CMD_PUSH_BEGIN: begin
        if (pend_r) dec_st = ST_ORDER;
        else if (!fits) dec_st = ST_FULL;
      end
      CMD_PUSH_BYTE: if (!pend_r) dec_st = ST_ORDER;
      CMD_PEEK, CMD_POP, CMD_READ_BYTE: if (cnt_r == '0) dec_st = ST_EMPTY;
      default: dec_st = ST_OK;
    endcase
  end

  assign stat.need_hdr_wr = (cmd_r == CMD_PUSH_BEGIN) && !pend_r && fits;
  assign stat.need_hdr_rd = (cmd_r inside {CMD_PEEK, CMD_POP, CMD_READ_BYTE})
                            && (cnt_r != '0);
  assign stat.need_pay_rd = (cmd_r == CMD_READ_BYTE) && (SW'(off_r) < SW'(flen));

  always_comb begin
    mwe = 1'b0;
    mwa = wr_cur_r[AW-1:0];
    mwd = dbyte_r;
    mre = 1'b0;
    mra = rd_cur_r[AW-1:0];
    case (dcmd.op)
      OP_DECIDE: begin
        if (cmd_r == CMD_PUSH_BYTE && pend_r) begin
          mwe = 1'b1;
          mwa = paddr_r[AW-1:0];
        end
      end
      OP_HDR_WR: begin
        mwe = 1'b1;
        mwa = hpos_r[AW-1:0] + AW'(dcmd.idx);
        case (dcmd.idx)
          2'd0: mwd = len_r[7:0];
          2'd1: mwd = len_r[15:8];
          2'd2: mwd = id_r[7:0];
          default: mwd = id_r[15:8];
        endcase
      end
      OP_HDR_RD: begin
        mre = 1'b1;
        mra = rd_cur_r[AW-1:0] + AW'(dcmd.idx);
      end
      OP_PAY_RD: begin
        mre = 1'b1;
        mra = paddr_s[AW-1:0];
      end
      default: mre = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    if (mre) mrd_r <= mem[mra];
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    if (dcmd.op == OP_LATCH) begin
      cmd_r   <= in_cmd;
      id_r    <= in_identifier;
      len_r   <= in_length;
      dbyte_r <= in_data_byte;
      off_r   <= in_offset;
      chk_r   <= in_check_capacity;
      cap_r   <= in_capacity;
      hid_r   <= '0;
      hlen_r  <= '0;
    end
    if (dcmd.op == OP_DECIDE) begin
      st_r   <= dec_st;
      hpos_r <= pos;
    end
    if (rd_lat_r) hb_r[rd_idx_r] <= mrd_r;
    rd_idx_r <= dcmd.idx;
    if (dcmd.op == OP_FINISH) begin
      hid_r  <= (cmd_r == CMD_READ_BYTE) ? 16'd0 : fid;
      hlen_r <= (cmd_r == CMD_READ_BYTE || (chk_r && cap_r < flen)) ? 16'd0 : flen;
      if (cmd_r == CMD_READ_BYTE && !stat.need_pay_rd) st_r <= ST_OFFSET;
    end
    if (dcmd.op == OP_RESULT) begin
      res_status          <= st_r;
      res_head_identifier <= hid_r;
      res_head_length     <= hlen_r;
      // payload byte arrives in the read register just before the result
      res_read_data       <= prd_r ? mrd_r : 8'd0;
      res_records_held    <= cnt_r;
      res_bytes_used      <= occ_r;
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cur_r <= '0; wrap_r <= '0; rd_cur_r <= '0; occ_r <= '0;
      cnt_r <= '0; pend_r <= 1'b0; prem_r <= '0; paddr_r <= '0;
      rd_lat_r <= 1'b0; prd_r <= 1'b0;
    end else begin
      rd_lat_r <= (dcmd.op == OP_HDR_RD);
      prd_r    <= (dcmd.op == OP_PAY_RD);
      if (dcmd.op == OP_DECIDE) begin
        case (cmd_r)
          CMD_PUSH_BEGIN: if (!pend_r && fits) begin
            occ_r    <= CW'(occ_s + total_s);
            wr_cur_r <= CW'(SW'(pos) + total_s);
            if (SW'(pos) + total_s > wrap_s) wrap_r <= CW'(SW'(pos) + total_s);
            paddr_r  <= CW'(SW'(pos) + HdrS);
            prem_r   <= len_r;
            if (len_r == 16'd0) cnt_r <= cnt_r + RW'(1);
            else pend_r <= 1'b1;
          end
          CMD_PUSH_BYTE: if (pend_r) begin
            paddr_r <= paddr_r + CW'(1);
            prem_r  <= prem_r - 16'd1;
            if (prem_r == 16'd1) begin
              pend_r <= 1'b0;
              cnt_r  <= cnt_r + RW'(1);
            end
          end
          CMD_PEEK, CMD_POP, CMD_READ_BYTE: if (cnt_r != '0 && rd_cur_r == wrap_r) begin
            rd_cur_r <= '0;
            wrap_r   <= wr_cur_r;
          end
          CMD_CLEAR: begin
            wr_cur_r <= '0; wrap_r <= '0; rd_cur_r <= '0; occ_r <= '0;
            cnt_r <= '0; pend_r <= 1'b0; prem_r <= '0; paddr_r <= '0;
          end
          default: cnt_r <= cnt_r;
        endcase
      end
      if (dcmd.op == OP_FINISH && cmd_r == CMD_POP) begin
        cnt_r    <= cnt_r - RW'(1);
        occ_r    <= (occ_s >= HdrS + SW'(flen)) ? CW'(occ_s - HdrS - SW'(flen)) : '0;
        rd_cur_r <= CW'(rc_s + HdrS + SW'(flen));
      end
    end
  end

endmodule

[hw/rtl/variable_record_ring_queue.sv]
// variable-length record queue in a byte ring. each input word carries one
// command (push_begin, push_byte, peek, read_byte, pop, clear) and yields one
// result word with status, head header, read byte and the counters after the
// command. records are stored as a 4-byte header (length lo/hi, id lo/hi) and
// payload, never split; a record that does not fit before the ring end goes to
// address 0. one word is handled at a time through a single byte-wide
// synchronous ram, so a new word is not accepted until the last one is through.
// steps per word: decide, result and hand-off for push_byte, clear, spare codes
// and any word refused or answered empty; four header writes more for an accepted
// push_begin; four header reads and a finish step more for peek, pop and a
// read_byte past the payload; one payload read more for a read_byte that returns
// a byte. out register holds the result until taken, holding off the input; the
// next word is accepted the cycle after. the ram needs no clearing.
module variable_record_ring_queue
  import vrrq_pkg::*;
#(
  parameter int unsigned RING_BYTES = RingBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0], identifier[18:3], length[34:19], data_byte[42:35],
  // offset[58:43], check_capacity[59], capacity[75:60], zero pad to 80
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, head_identifier, head_length, read_data, records_held,
  // bytes_used, lowest first, zero padded to whole bytes
  output logic [((3+16+16+8+$clog2(RING_BYTES/HeaderBytes+1)
                  +$clog2(RING_BYTES+1)+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned RW = $clog2(RING_BYTES/HeaderBytes + 1);
  localparam int unsigned CW = $clog2(RING_BYTES + 1);
  localparam int unsigned OW = ((3+16+16+8+RW+CW+7)/8)*8;

  dp_cmd_t       dcmd;
  dp_stat_t      stat;
  logic [2:0]    r_status;
  logic [15:0]   r_hid, r_hlen;
  logic [7:0]    r_rdata;
  logic [RW-1:0] r_cnt;
  logic [CW-1:0] r_used;

  vrrq_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .dcmd
  );

  vrrq_dp #(.RING_BYTES(RING_BYTES)) u_dp (
    .clk, .rst_n,
    .in_cmd            (in_tdata[2:0]),
    .in_identifier     (in_tdata[18:3]),
    .in_length         (in_tdata[34:19]),
    .in_data_byte      (in_tdata[42:35]),
    .in_offset         (in_tdata[58:43]),
    .in_check_capacity (in_tdata[59]),
    .in_capacity       (in_tdata[75:60]),
    .dcmd, .stat,
    .res_status          (r_status),
    .res_head_identifier (r_hid),
    .res_head_length     (r_hlen),
    .res_read_data       (r_rdata),
    .res_records_held    (r_cnt),
    .res_bytes_used      (r_used)
  );

  assign out_tdata = OW'({r_used, r_cnt, r_rdata, r_hlen, r_hid, r_status});

endmodule
